### hdl/first_fit_block_allocator_core_assert.svh
// Assertion macros for the allocator core.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Checked only while out of reset.
`define FFBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge.
`define FFBA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ffba_pkg.sv
package ffba_pkg;

    localparam int ARENA_UNITS = 1024;
    localparam int ADDR_W      = $clog2(ARENA_UNITS);
    localparam int PTR_W       = ADDR_W + 1;
    localparam int REQ_W       = 10;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;

    localparam logic [PTR_W-1:0] END_MARK = PTR_W'(ARENA_UNITS);

    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_GRANT = 2'd1,
        RES_FAIL  = 2'd2,
        RES_FREED = 2'd3
    } res_op_t;

    typedef struct packed {
        logic    load;
        logic    read;
        logic    advance;
        logic    split_write;
        logic    link_write;
        logic    free_write;
        res_op_t res_op;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic req_zero;
        logic addr_zero;
        logic walk_end;
        logic fits;
        logic can_split;
        logic out_busy;
    } status_t;

endpackage

### hdl/first_fit_block_allocator_core.sv
// First-fit allocator over a 1024-unit arena kept as a singly linked free list.
// One request is handled at a time. An allocate walks the list, visiting each free
// block with one read of the size and link stores and then one compare, then does the
// write-back, preceded by a split write when the block is split. A zero request
// fails without a walk. The single read port on each store sets the walk speed.
// The result sits in an output register, so a finished result may wait while the
// next request is taken. No clearing pass follows reset.
module first_fit_block_allocator_core
    import ffba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // request_units[9:0], block_address[19:10], zero
    input  logic [0:0]            s_tuser,  // kind[0]: 0 allocate, 1 free
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // granted_address[9:0], zero
    output logic [0:0]            m_tuser   // failed[0]
);

    `include "first_fit_block_allocator_core_assert.svh"

    cmd_t       cmd;
    status_t    status;
    logic [2:0] wr_cmds;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffba_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_data    (s_tdata),
        .in_kind    (s_tuser[0]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata),
        .out_failed (m_tuser[0])
    );

    assign wr_cmds = {cmd.split_write, cmd.link_write, cmd.free_write};

    `FFBA_ASSERT(a_fail_no_addr, m_tvalid && m_tuser[0] |-> (m_tdata == '0), "fail with address")
    `FFBA_ASSERT(a_one_write_cmd, $onehot0(wr_cmds), "conflicting store writes")
    `FFBA_ASSERT(a_busy_after_take, s_tvalid && s_tready |=> !s_tready, "request taken while busy")
    `FFBA_ASSERT(a_load_when_ready, cmd.load |-> s_tready && s_tvalid, "load without transfer")

endmodule

### hdl/ffba_ctrl.sv
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOKUP = 7'b0000010,
        S_EVAL   = 7'b0000100,
        S_SPLIT  = 7'b0001000,
        S_LINK   = 7'b0010000,
        S_FREE   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_op = RES_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (status.is_free)
                begin
                    state_next = S_FREE;
                end
                else if (status.req_zero || status.walk_end)
                begin
                    cmd.res_op = RES_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!status.fits)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_LOOKUP;
                end
                else if (status.can_split)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    state_next = S_LINK;
                end
            end
            S_SPLIT:
            begin
                cmd.split_write = 1'b1;
                state_next      = S_LINK;
            end
            S_LINK:
            begin
                cmd.link_write = 1'b1;
                cmd.res_op     = RES_GRANT;
                state_next     = S_DONE;
            end
            S_FREE:
            begin
                cmd.free_write = !status.addr_zero;
                cmd.res_op     = RES_FREED;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/ffba_dp.sv
module ffba_dp
    import ffba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_kind,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_failed
);

    logic [PTR_W-1:0] size_mem [ARENA_UNITS];
    logic [PTR_W-1:0] link_mem [ARENA_UNITS];

    logic [PTR_W-1:0]  head_reg;
    logic              size0_wr_reg;
    logic              link0_wr_reg;
    logic              out_valid_reg;

    logic [PTR_W-1:0]  cur_reg;
    logic [PTR_W-1:0]  prev_reg;
    logic [PTR_W-1:0]  visits_reg;
    logic [PTR_W-1:0]  need_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              kind_reg;
    logic [PTR_W-1:0]  size_rd_reg;
    logic [PTR_W-1:0]  link_rd_reg;
    logic              size_ovr_reg;
    logic              link_ovr_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic              res_fail_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_fail_reg;

    logic [PTR_W-1:0]  size_val;
    logic [PTR_W-1:0]  link_val;
    logic [PTR_W-1:0]  rem_sum;
    logic [PTR_W-1:0]  succ;
    logic [ADDR_W-1:0] free_hdr;
    logic              split_ok;

    logic              size_we;
    logic [ADDR_W-1:0] size_wa;
    logic [PTR_W-1:0]  size_wd;
    logic              link_we;
    logic [ADDR_W-1:0] link_wa;
    logic [PTR_W-1:0]  link_wd;

    // entry zero reads as the whole-arena block until first written
    assign size_val = size_ovr_reg ? END_MARK : size_rd_reg;
    assign link_val = link_ovr_reg ? END_MARK : link_rd_reg;
    assign rem_sum  = cur_reg + need_reg;
    assign split_ok = (size_val > need_reg) && !rem_sum[PTR_W-1];
    assign succ     = split_ok ? rem_sum : link_val;
    assign free_hdr = addr_reg - ADDR_W'(1);

    assign status.is_free   = kind_reg;
    assign status.req_zero  = (need_reg == PTR_W'(1));
    assign status.addr_zero = (addr_reg == '0);
    assign status.walk_end  = cur_reg[PTR_W-1] | visits_reg[PTR_W-1];
    assign status.fits      = (size_val >= need_reg);
    assign status.can_split = split_ok;
    assign status.out_busy  = out_valid_reg && !out_ready;

    always_comb
    begin
        size_we = 1'b0;
        size_wa = cur_reg[ADDR_W-1:0];
        size_wd = need_reg;
        link_we = 1'b0;
        link_wa = prev_reg[ADDR_W-1:0];
        link_wd = succ;
        if (cmd.split_write)
        begin
            size_we = 1'b1;
            size_wa = rem_sum[ADDR_W-1:0];
            size_wd = size_val - need_reg;
            link_we = 1'b1;
            link_wa = rem_sum[ADDR_W-1:0];
            link_wd = link_val;
        end
        else if (cmd.link_write)
        begin
            size_we = split_ok;
            link_we = !prev_reg[PTR_W-1];
        end
        else if (cmd.free_write)
        begin
            link_we = 1'b1;
            link_wa = free_hdr;
            link_wd = head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_wa] <= size_wd;
        end
        if (cmd.read)
        begin
            size_rd_reg <= size_mem[cur_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (cmd.read)
        begin
            link_rd_reg <= link_mem[cur_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            size0_wr_reg  <= 1'b0;
            link0_wr_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.link_write && prev_reg[PTR_W-1])
            begin
                head_reg <= succ;
            end
            else if (cmd.free_write)
            begin
                head_reg <= {1'b0, free_hdr};
            end
            if (size_we && (size_wa == '0))
            begin
                size0_wr_reg <= 1'b1;
            end
            if (link_we && (link_wa == '0))
            begin
                link0_wr_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= in_kind;
            need_reg   <= {1'b0, in_data[REQ_W-1:0]} + PTR_W'(1);
            addr_reg   <= in_data[2*REQ_W-1:REQ_W];
            cur_reg    <= head_reg;
            prev_reg   <= END_MARK;
            visits_reg <= '0;
        end
        else if (cmd.advance)
        begin
            prev_reg   <= cur_reg;
            cur_reg    <= link_val;
            visits_reg <= visits_reg + PTR_W'(1);
        end
        if (cmd.read)
        begin
            size_ovr_reg <= (cur_reg[ADDR_W-1:0] == '0) && !size0_wr_reg;
            link_ovr_reg <= (cur_reg[ADDR_W-1:0] == '0) && !link0_wr_reg;
        end
        case (cmd.res_op)
            RES_GRANT:
            begin
                res_addr_reg <= cur_reg[ADDR_W-1:0] + ADDR_W'(1);
                res_fail_reg <= 1'b0;
            end
            RES_FAIL:
            begin
                res_addr_reg <= '0;
                res_fail_reg <= 1'b1;
            end
            RES_FREED:
            begin
                res_addr_reg <= '0;
                res_fail_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            out_addr_reg <= res_addr_reg;
            out_fail_reg <= res_fail_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = {(OUT_DATA_W - ADDR_W)'(0), out_addr_reg};
    assign out_failed = out_fail_reg;

endmodule
